[design/ofht_pkg.sv]
// shared types and codes for the open file handle table
// no dependencies; used by the controller, datapath and top level
package ofht_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic [2:0] KIND_CREATE        = 3'd0;
    localparam logic [2:0] KIND_LOOKUP_OWNER  = 3'd1;
    localparam logic [2:0] KIND_LOOKUP_HANDLE = 3'd2;
    localparam logic [2:0] KIND_UPDATE        = 3'd3;
    localparam logic [2:0] KIND_RELEASE       = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    localparam logic [2:0] ADDR_FIRST_HANDLE = 3'd0;

    typedef struct packed {
        logic [63:0] handle;
        logic [63:0] inode;
        logic [31:0] pid;
        logic [31:0] flags;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic create;
        logic scan_start;
        logic scan_run;
        logic take_hit;
        logic shift_start;
        logic shift_run;
        logic count_dec;
        logic set_miss;
        logic fin;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] kind;
        logic       hit;
        logic       scan_done;
        logic       out_free;
    } sts_t;

endpackage

[design/ofht_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module ofht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/ofht_ctrl.sv]
// request sequencer: accept, decode, scan, compaction shift, result hand-off
// depends on ofht_pkg for the command and status structs
module ofht_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ofht_pkg::sts_t  sts,
    output ofht_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (sts.kind)
                    ofht_pkg::KIND_CREATE: begin
                        cmd.create = 1'b1;
                        state_next = S_FIN;
                    end
                    ofht_pkg::KIND_LOOKUP_OWNER,
                    ofht_pkg::KIND_LOOKUP_HANDLE,
                    ofht_pkg::KIND_UPDATE,
                    ofht_pkg::KIND_RELEASE: begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    default: begin
                        cmd.set_miss = 1'b1;
                        state_next   = S_FIN;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.hit) begin
                    cmd.take_hit = 1'b1;
                    if (sts.kind == ofht_pkg::KIND_RELEASE) begin
                        cmd.shift_start = 1'b1;
                        state_next      = S_SHIFT;
                    end else begin
                        state_next = S_FIN;
                    end
                end else if (sts.scan_done) begin
                    cmd.set_miss = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_SHIFT: begin
                cmd.shift_run = 1'b1;
                if (sts.scan_done) begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_FIN;
                end
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[design/ofht_dp.sv]
// table datapath: entry ram, counters, scan pipeline, result and output registers
// depends on ofht_pkg and ofht_ram
module ofht_dp #(
    parameter int TABLE_DEPTH = ofht_pkg::TABLE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  ofht_pkg::cmd_t  cmd,
    output ofht_pkg::sts_t  sts,
    input  logic [2:0]      s_kind,
    input  logic [63:0]     s_key_handle,
    input  logic [63:0]     s_inode_number,
    input  logic [31:0]     s_process_id,
    input  logic [31:0]     s_open_flags,
    input  logic [63:0]     s_new_handle,
    input  logic            cfg_we,
    input  logic [63:0]     cfg_data,
    output logic [63:0]     first_handle,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      m_status,
    output logic [63:0]     m_found_handle,
    output logic [63:0]     m_found_inode,
    output logic [31:0]     m_found_pid,
    output logic [31:0]     m_found_flags
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    // request word
    logic [2:0]  kind_reg;
    logic [63:0] key_reg;
    logic [63:0] ino_reg;
    logic [31:0] pid_reg;
    logic [31:0] flags_reg;
    logic [63:0] nh_reg;

    logic [CNT_W-1:0] count_reg;
    logic [63:0]      next_handle_reg;
    logic             exhausted_reg;
    logic [63:0]      first_handle_reg;

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] pend_idx_reg;
    logic             pend_reg;

    logic [1:0]       res_status_reg;
    ofht_pkg::entry_t res_entry_reg;

    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    ofht_pkg::entry_t out_entry_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    ofht_pkg::entry_t ram_wdata;
    ofht_pkg::entry_t ram_rdata;

    logic             full;
    logic             last_handle;
    logic             create_ok;
    logic             hit;
    logic             issue;
    logic             out_free;
    ofht_pkg::entry_t upd_entry;
    logic [CNT_W-1:0] shift_dst;

    ofht_ram #(
        .WIDTH (ofht_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign full        = (count_reg >= DEPTH_C);
    assign last_handle = (next_handle_reg == '1);
    assign create_ok   = cmd.create && !exhausted_reg && !full;
    assign upd_entry   = '{handle: nh_reg, inode: ino_reg, pid: pid_reg, flags: flags_reg};
    assign shift_dst   = pend_idx_reg - CNT_W'(1);

    // compare of the word read last cycle
    always_comb begin
        if (kind_reg == ofht_pkg::KIND_LOOKUP_OWNER) begin
            hit = pend_reg && (ram_rdata.inode == ino_reg) && (ram_rdata.pid == pid_reg);
        end else begin
            hit = pend_reg && (ram_rdata.handle == key_reg);
        end
    end

    assign issue    = (cmd.scan_run || cmd.shift_run) && (idx_reg < count_reg)
                      && !(cmd.scan_run && hit);
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[IDX_W-1:0];
        ram_wdata = '{handle: next_handle_reg, inode: ino_reg, pid: pid_reg, flags: flags_reg};
        if (create_ok) begin
            ram_we = 1'b1;
        end else if (cmd.take_hit && kind_reg == ofht_pkg::KIND_UPDATE) begin
            ram_we    = 1'b1;
            ram_waddr = pend_idx_reg[IDX_W-1:0];
            ram_wdata = upd_entry;
        end else if (cmd.shift_run && pend_reg) begin
            // move the entry one slot toward the front
            ram_we    = 1'b1;
            ram_waddr = shift_dst[IDX_W-1:0];
            ram_wdata = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg  <= s_kind;
            key_reg   <= s_key_handle;
            ino_reg   <= s_inode_number;
            pid_reg   <= s_process_id;
            flags_reg <= s_open_flags;
            nh_reg    <= s_new_handle;
        end
        if (cmd.scan_start) begin
            idx_reg <= '0;
        end else if (cmd.shift_start) begin
            idx_reg <= pend_idx_reg + CNT_W'(1);
        end else if (issue) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
        if (issue) begin
            pend_idx_reg <= idx_reg;
        end
        if (cmd.create) begin
            if (exhausted_reg) begin
                res_status_reg <= ofht_pkg::ST_EXHAUSTED;
                res_entry_reg  <= '0;
            end else if (full) begin
                res_status_reg <= ofht_pkg::ST_FULL;
                res_entry_reg  <= '0;
            end else begin
                res_entry_reg  <= '{handle: next_handle_reg, inode: 64'd0, pid: 32'd0,
                                   flags: 32'd0};
                res_status_reg <= last_handle ? ofht_pkg::ST_EXHAUSTED : ofht_pkg::ST_OK;
            end
        end else if (cmd.take_hit) begin
            res_status_reg <= ofht_pkg::ST_OK;
            res_entry_reg  <= (kind_reg == ofht_pkg::KIND_UPDATE) ? upd_entry : ram_rdata;
        end else if (cmd.set_miss) begin
            res_status_reg <= ofht_pkg::ST_NOT_FOUND;
            res_entry_reg  <= '0;
        end
        if (cmd.fin) begin
            out_status_reg <= res_status_reg;
            out_entry_reg  <= res_entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg        <= '0;
            next_handle_reg  <= 64'd1;
            exhausted_reg    <= 1'b0;
            first_handle_reg <= 64'd1;
            pend_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                first_handle_reg <= cfg_data;
                next_handle_reg  <= cfg_data;
                exhausted_reg    <= 1'b0;
            end else if (create_ok) begin
                if (last_handle) begin
                    exhausted_reg <= 1'b1;
                end else begin
                    next_handle_reg <= next_handle_reg + 64'd1;
                end
            end
            if (create_ok) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.count_dec) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.scan_start || cmd.shift_start) begin
                pend_reg <= 1'b0;
            end else begin
                pend_reg <= issue;
            end
            if (cmd.fin) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.kind      = kind_reg;
    assign sts.hit       = hit;
    assign sts.scan_done = !pend_reg && (idx_reg >= count_reg);
    assign sts.out_free  = out_free;

    assign first_handle   = first_handle_reg;
    assign m_valid        = out_valid_reg;
    assign m_status       = out_status_reg;
    assign m_found_handle = out_entry_reg.handle;
    assign m_found_inode  = out_entry_reg.inode;
    assign m_found_pid    = out_entry_reg.pid;
    assign m_found_flags  = out_entry_reg.flags;

endmodule

[design/open_file_handle_table_unit.sv]
// open file handle table, top level: apb register decode, controller and datapath
// create appends the new entry at the end of the table; lookup, update and release scan
// the entries in order from index 0 and stop at the first hit, else report not found
// a release with a hit then moves each later entry one slot toward the front
// one word is in work at a time; the next is accepted while a result waits in the output
// reset clears control state; table contents are not cleared
module open_file_handle_table_unit #(
    parameter int TABLE_DEPTH = ofht_pkg::TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [63:0] s_key_handle,
    input  logic [63:0] s_inode_number,
    input  logic [31:0] s_process_id,
    input  logic [31:0] s_open_flags,
    input  logic [63:0] s_new_handle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_found_handle,
    output logic [63:0] m_found_inode,
    output logic [31:0] m_found_pid,
    output logic [31:0] m_found_flags,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    ofht_pkg::cmd_t cmd;
    ofht_pkg::sts_t sts;
    logic           cfg_we;
    logic [63:0]    first_handle;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == ofht_pkg::ADDR_FIRST_HANDLE);
    assign prdata = (paddr == ofht_pkg::ADDR_FIRST_HANDLE) ? first_handle : 64'd0;

    ofht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ofht_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_kind         (s_kind),
        .s_key_handle   (s_key_handle),
        .s_inode_number (s_inode_number),
        .s_process_id   (s_process_id),
        .s_open_flags   (s_open_flags),
        .s_new_handle   (s_new_handle),
        .cfg_we         (cfg_we),
        .cfg_data       (pwdata),
        .first_handle   (first_handle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_found_handle (m_found_handle),
        .m_found_inode  (m_found_inode),
        .m_found_pid    (m_found_pid),
        .m_found_flags  (m_found_flags)
    );

endmodule
